[hw/rtl/sms_pkg.sv]
`default_nettype none

package sms_pkg;

	// Sample width of the stream words
	localparam int SAMPLE_BITS = 16;

	// Default and width of the half-width register
	localparam int MAX_HALF_WIDTH_DEF = 4;
	localparam int HALF_WIDTH_BITS = 3;
	localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RESET = 3'd1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          end_of_line;
	} sms_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          last_out;
	} sms_out_t;

endpackage

`default_nettype wire

[hw/rtl/sliding_median_smoother_top.sv]
`default_nettype none

// Channel   Direction  Handshake              Word
// ------    ---------  ---------------------  ------------------------------
// in        input      in_valid / in_stall    sms_in_t  (sample, end of line)
// out       output     out_valid / out_stall  sms_out_t (sample, last of line)
// cfg       input      cfg_we                 half-width, 3 bits
//
// Cycles: one word in per cycle while a line streams, each giving at most one
// word out; the rank-compare median of the 2*hw+1 window taps is formed as the
// word is accepted and the result register drives it out on the next cycle.
// An end-of-line word adds up to hw raw tail words, and the input waits while
// they drain. The input takes a word in the cycle the last pending one leaves,
// so an output stall holds both sides. Reset clears window, count and results.

module sliding_median_smoother_top
	import sms_pkg::*;
#(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire sms_in_t                    in_word,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      sms_out_t                   out_word,
	input  wire logic                       cfg_we,
	input  wire logic [HALF_WIDTH_BITS-1:0] cfg_wdata
);

	localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int CNT_W = $clog2(2 * MAX_HALF_WIDTH + 2);
	localparam int HW_W  = $clog2(MAX_HALF_WIDTH + 1);
	localparam int IDX_W = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(DEPTH);

	// Configuration
	logic [HALF_WIDTH_BITS-1:0] half_width_q;
	logic [HW_W-1:0]            hw_eff;
	logic [CNT_W-1:0]           hw_x;
	logic [CNT_W-1:0]           span;

	// Line state
	logic signed [SAMPLE_BITS-1:0] win_q    [DEPTH];
	logic signed [SAMPLE_BITS-1:0] win_next [DEPTH];
	logic [CNT_W-1:0]              seen_q;

	// Pending result: one center word, then flushed tail words
	logic                          main_pend_q;
	logic signed [SAMPLE_BITS-1:0] main_q;
	logic                          main_last_q;
	logic [HW_W-1:0]               flush_left_q;
	logic signed [SAMPLE_BITS-1:0] flush_q [MAX_HALF_WIDTH];

	logic                          in_take;
	logic                          out_take;
	logic                          one_left;
	logic                          none_left;
	logic [HW_W-1:0]               flush_dec;

	// Accept-side results
	logic signed [SAMPLE_BITS-1:0] med;
	logic signed [SAMPLE_BITS-1:0] tap;
	logic [CNT_W-1:0]              rank_c;
	logic                          main_v;
	logic signed [SAMPLE_BITS-1:0] main_v_val;
	logic [CNT_W-1:0]              hw_m1;
	logic [CNT_W-1:0]              top;
	logic [HW_W-1:0]               flush_n;

	// Clamp the register to the window the block was built for
	always_comb begin
		if (int'(half_width_q) > MAX_HALF_WIDTH) begin
			hw_eff = HW_W'(MAX_HALF_WIDTH);
		end else begin
			hw_eff = HW_W'(half_width_q);
		end
		hw_x = CNT_W'(hw_eff);
		span = hw_x << 1;
	end

	// Shift the new sample in at tap 0
	always_comb begin
		win_next[0] = in_word.sample_in;
		for (int d = 1; d < DEPTH; d++) begin
			win_next[d] = win_q[d-1];
		end
	end

	// Rank compare: tap i ranks by the taps smaller than it, ties broken by tap
	// position, so exactly one tap of the window holds rank hw.
	always_comb begin
		med = '0;
		tap = '0;
		rank_c = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rank_c = '0;
			for (int j = 0; j < DEPTH; j++) begin
				if (j != i && CNT_W'(j) <= span) begin
					if (win_next[j] < win_next[i] ||
					    (win_next[j] == win_next[i] && j < i)) begin
						rank_c = rank_c + CNT_W'(1);
					end
				end
			end
			if (CNT_W'(i) <= span && rank_c == hw_x) begin
				med = med | win_next[i];
			end
			if (CNT_W'(i) == hw_x) begin
				tap = tap | win_next[i];
			end
		end
	end

	// Center word: median once the full window is in, raw sample near the start
	always_comb begin
		main_v     = (seen_q >= hw_x);
		main_v_val = (seen_q >= span) ? med : tap;
		hw_m1      = hw_x - CNT_W'(1);
		top        = (seen_q < hw_m1) ? seen_q : hw_m1;
		if (in_word.end_of_line && hw_x != '0) begin
			flush_n = HW_W'(top + CNT_W'(1));
		end else begin
			flush_n = '0;
		end
	end

	// Output side
	assign out_valid = main_pend_q || (flush_left_q != '0);
	assign out_take  = out_valid && !out_stall;
	assign none_left = !main_pend_q && (flush_left_q == '0);
	assign one_left  = (main_pend_q && flush_left_q == '0) ||
	                   (!main_pend_q && flush_left_q == HW_W'(1));
	assign in_stall  = !(none_left || (one_left && !out_stall));
	assign in_take   = in_valid && !in_stall;
	assign flush_dec = flush_left_q - HW_W'(1);

	always_comb begin
		if (main_pend_q) begin
			out_word.sample_out = main_q;
			out_word.last_out   = main_last_q;
		end else begin
			out_word.sample_out = flush_q[flush_dec[IDX_W-1:0]];
			out_word.last_out   = (flush_left_q == HW_W'(1));
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RESET;
			seen_q       <= '0;
			main_pend_q  <= 1'b0;
			flush_left_q <= '0;
			for (int d = 0; d < DEPTH; d++) begin
				win_q[d] <= '0;
			end
		end else begin
			if (cfg_we) begin
				half_width_q <= cfg_wdata;
			end
			if (in_take) begin
				// Load the next result set; the last old word leaves now
				main_pend_q  <= main_v;
				flush_left_q <= flush_n;
				if (in_word.end_of_line) begin
					seen_q <= '0;
					for (int d = 0; d < DEPTH; d++) begin
						win_q[d] <= '0;
					end
				end else begin
					if (seen_q < COUNT_CAP) begin
						seen_q <= seen_q + CNT_W'(1);
					end
					for (int d = 0; d < DEPTH; d++) begin
						win_q[d] <= win_next[d];
					end
				end
			end else if (out_take) begin
				// Advance: center word first, then the tail, newest last
				if (main_pend_q) begin
					main_pend_q <= 1'b0;
				end else begin
					flush_left_q <= flush_dec;
				end
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			main_q      <= main_v_val;
			main_last_q <= in_word.end_of_line && (hw_x == '0);
			for (int i = 0; i < MAX_HALF_WIDTH; i++) begin
				flush_q[i] <= win_next[i];
			end
		end
	end

endmodule

`default_nettype wire
